### hdl/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg: shared types and constants for the lcd scanline timing block
// Frame geometry, mode and command codes, and the result record.
// ----------------------------------------------------------------------------
package lst_pkg;

    // frame geometry
    localparam int LINE_CYCLES   = 456;
    localparam int VISIBLE_LINES = 144;
    localparam int TOTAL_LINES   = 154;

    localparam int FRAME_CYCLES  = TOTAL_LINES * LINE_CYCLES;
    localparam int VBLANK_POINT  = VISIBLE_LINES * LINE_CYCLES + 4;
    localparam int FRAME_TOP     = (FRAME_CYCLES > VBLANK_POINT) ? FRAME_CYCLES
                                                                 : VBLANK_POINT;

    // counter widths, with room for the sum with one tick count
    localparam int CNT_W  = $clog2(FRAME_TOP + 256);
    localparam int LC_W   = $clog2(LINE_CYCLES + 256);
    localparam int LINE_W = 8;

    // mode change points within a line
    localparam int OAM_START   = 4;
    localparam int XFER_START  = 80;
    localparam int HBLK_START  = 250;

    // reset value of the upper status bits (bit 7 set)
    localparam logic [4:0] STAT_UPPER_RST = 5'h10;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    typedef enum logic {
        CMD_TICK       = 1'b0,
        CMD_STAT_WRITE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [1:0]        mode;
        logic [7:0]        stat_byte;
        logic              vblank_irq;
        logic              stat_irq;
        logic              render_line;
        logic              frame_done;
    } t_result;

endpackage

### hdl/lcd_scanline_timing_status.sv
// ----------------------------------------------------------------------------
// lcd_scanline_timing_status: lcd scanline timing and status controller
// Tracks frame and line position, display mode, status byte and interrupts.
// ----------------------------------------------------------------------------
// Each request (a time tick or a status write) is taken while o_ready is high
// and its result is registered into the result buffer, so one request per
// clock is sustained as long as results are taken. The whole update is one
// pass through a single adder and compare per counter into the state
// registers; a two-entry result buffer lets requests keep flowing while a
// result waits to be taken. Results come out in request order, one per request.
module lcd_scanline_timing_status
    import lst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [7:0]  i_cycles,
    input  logic        i_lcd_on,
    input  logic [7:0]  i_lyc,
    input  logic [7:0]  i_write_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_line,
    output logic [1:0]  o_mode,
    output logic [7:0]  o_stat_byte,
    output logic        o_vblank_irq,
    output logic        o_stat_irq,
    output logic        o_render_line,
    output logic        o_frame_done
);

    logic    accept;
    t_result core_result;
    t_result buf_result;

    assign accept = i_valid && o_ready;

    // timing state and update
    lst_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_cycles      (i_cycles),
        .i_lcd_on      (i_lcd_on),
        .i_lyc         (i_lyc),
        .i_write_value (i_write_value),
        .o_result      (core_result)
    );

    // result buffer
    lst_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     (core_result),
        .o_not_full (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (buf_result)
    );

    assign o_line        = buf_result.line;
    assign o_mode        = buf_result.mode;
    assign o_stat_byte   = buf_result.stat_byte;
    assign o_vblank_irq  = buf_result.vblank_irq;
    assign o_stat_irq    = buf_result.stat_irq;
    assign o_render_line = buf_result.render_line;
    assign o_frame_done  = buf_result.frame_done;

`ifndef SYNTHESIS
    // an accepted request always leaves a result behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted request left no result");

    // line stays inside the frame
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_line < 8'(TOTAL_LINES)))
        else $error("line out of range");

    // render strobe only on entry to transfer, frame strobe only on vblank
    a_strobe_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((!o_render_line || (o_mode == MODE_XFER)) &&
                     (!o_frame_done || (o_mode == MODE_VBLANK))))
        else $error("strobe does not match mode");

    // status byte carries the mode
    a_stat_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_stat_byte[1:0] == o_mode))
        else $error("status mode bits disagree");
`endif

endmodule

### hdl/lst_core.sv
// ----------------------------------------------------------------------------
// lst_core: timing state and per-request update
// Holds the frame and line counters, line, mode and status bits, and works
// out the next state and the result for each accepted request.
// ----------------------------------------------------------------------------
module lst_core
    import lst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_command,
    input  logic [7:0]  i_cycles,
    input  logic        i_lcd_on,
    input  logic [7:0]  i_lyc,
    input  logic [7:0]  i_write_value,
    output t_result     o_result
);

    localparam logic [CNT_W-1:0]  FRAME_CYC_C = CNT_W'(FRAME_CYCLES);
    localparam logic [CNT_W-1:0]  VBLANK_C    = CNT_W'(VBLANK_POINT);
    localparam logic [LC_W-1:0]   LINE_CYC_C  = LC_W'(LINE_CYCLES);
    localparam logic [LINE_W-1:0] LAST_LINE_C = LINE_W'(TOTAL_LINES - 1);
    localparam logic [LINE_W-1:0] VIS_C       = LINE_W'(VISIBLE_LINES);

    logic [CNT_W-1:0]  r_frame_cnt, n_frame_cnt;
    logic [LC_W-1:0]   r_line_cnt,  n_line_cnt;
    logic [LINE_W-1:0] r_line,      n_line;
    t_mode             r_mode,      n_mode;
    logic [4:0]        r_stat_upper, n_stat_upper;
    logic              r_coin,      n_coin;

    logic [CNT_W-1:0]  frame_sum;
    logic [LC_W-1:0]   lc_sum;
    logic              lc_wrap;
    logic [LINE_W-1:0] tick_line;
    logic [LC_W-1:0]   tick_lc;
    t_mode             tick_mode;
    logic              vblank_irq, stat_irq, render_line, frame_done;

    // counter advance; the line counter wraps at most once per tick
    always_comb begin
        frame_sum = r_frame_cnt + CNT_W'(i_cycles);
        lc_sum    = r_line_cnt + LC_W'(i_cycles);
        lc_wrap   = (lc_sum >= LINE_CYC_C);
        tick_lc   = lc_wrap ? (lc_sum - LINE_CYC_C) : lc_sum;
        if (!lc_wrap) begin
            tick_line = r_line;
        end else if (r_line == LAST_LINE_C) begin
            tick_line = '0;
        end else begin
            tick_line = r_line + LINE_W'(1);
        end
    end

    // mode from line and position within the line
    always_comb begin
        tick_mode = MODE_HBLANK;
        if (tick_line < VIS_C) begin
            if (tick_lc > LC_W'(HBLK_START)) begin
                tick_mode = MODE_HBLANK;
            end else if (tick_lc > LC_W'(XFER_START)) begin
                tick_mode = MODE_XFER;
            end else if (tick_lc > LC_W'(OAM_START)) begin
                tick_mode = MODE_OAM;
            end
        end else if (tick_line == VIS_C) begin
            if (tick_lc > LC_W'(OAM_START)) begin
                tick_mode = MODE_VBLANK;
            end
        end else begin
            tick_mode = MODE_VBLANK;
        end
    end

    // next state and flags per command
    always_comb begin
        n_frame_cnt  = r_frame_cnt;
        n_line_cnt   = r_line_cnt;
        n_line       = r_line;
        n_mode       = r_mode;
        n_stat_upper = r_stat_upper;
        n_coin       = r_coin;
        vblank_irq   = 1'b0;
        stat_irq     = 1'b0;
        render_line  = 1'b0;
        frame_done   = 1'b0;
        if (i_command == CMD_STAT_WRITE) begin
            n_stat_upper = i_write_value[7:3];
        end else if (!i_lcd_on) begin
            n_frame_cnt     = '0;
            n_line_cnt      = '0;
            n_line          = '0;
            n_mode          = MODE_HBLANK;
            n_stat_upper[4] = 1'b1;
        end else begin
            n_frame_cnt = (frame_sum >= FRAME_CYC_C) ? (frame_sum - FRAME_CYC_C) : frame_sum;
            n_line_cnt  = tick_lc;
            n_line      = tick_line;
            n_mode      = tick_mode;
            n_coin      = (tick_line == i_lyc);
            vblank_irq  = (n_frame_cnt >= VBLANK_C) && (r_frame_cnt < VBLANK_C);
            if ((r_line != i_lyc) && (tick_line == i_lyc) && r_stat_upper[3]) begin
                stat_irq = 1'b1;
            end
            // mode entry events
            if (tick_mode != r_mode) begin
                unique case (tick_mode)
                    MODE_VBLANK: begin
                        frame_done = 1'b1;
                        if (r_stat_upper[1] || r_stat_upper[2]) stat_irq = 1'b1;
                    end
                    MODE_HBLANK: begin
                        if (r_stat_upper[0]) stat_irq = 1'b1;
                    end
                    MODE_OAM: begin
                        if (r_stat_upper[2]) stat_irq = 1'b1;
                    end
                    MODE_XFER: begin
                        render_line = 1'b1;
                    end
                    default: begin
                        render_line = 1'b0;
                    end
                endcase
            end
        end
    end

    // result record
    always_comb begin
        o_result.line        = n_line;
        o_result.mode        = n_mode;
        o_result.stat_byte   = {n_stat_upper, n_coin, n_mode};
        o_result.vblank_irq  = vblank_irq;
        o_result.stat_irq    = stat_irq;
        o_result.render_line = render_line;
        o_result.frame_done  = frame_done;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cnt  <= '0;
            r_line_cnt   <= '0;
            r_line       <= '0;
            r_mode       <= MODE_VBLANK;
            r_stat_upper <= STAT_UPPER_RST;
            r_coin       <= 1'b1;
        end else if (i_accept) begin
            r_frame_cnt  <= n_frame_cnt;
            r_line_cnt   <= n_line_cnt;
            r_line       <= n_line;
            r_mode       <= n_mode;
            r_stat_upper <= n_stat_upper;
            r_coin       <= n_coin;
        end
    end

endmodule

### hdl/lst_out_buf.sv
// ----------------------------------------------------------------------------
// lst_out_buf: two-entry result buffer
// Registers each result and keeps accepting while one result waits.
// ----------------------------------------------------------------------------
module lst_out_buf
    import lst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_not_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_not_full = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign pop        = o_valid && i_ready;
    assign o_data     = r_data[r_rd_ptr];

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
